// ===== rtl/rbc_pkg.sv =====
// Package for the redundant binary counter: digit and row widths, the row type
// of the digit memory and the result record of a row scan. No dependencies.
package rbc_pkg;

    localparam int DCNT_W         = 11;
    localparam int POS_IN_W       = 10;
    localparam int CHG_W          = 3;
    localparam int VAL_W          = 2;
    localparam int ROW_DIGITS     = 16;
    localparam int OFF_W          = 4;
    localparam int DEF_MAX_DIGITS = 1024;

    localparam logic [DCNT_W-1:0] DCNT_RESET = 11'd1024;
    localparam logic [VAL_W-1:0]  DIGIT_ZERO = 2'd0;
    localparam logic [VAL_W-1:0]  DIGIT_ONE  = 2'd1;
    localparam logic [VAL_W-1:0]  DIGIT_TWO  = 2'd2;
    localparam logic [VAL_W-1:0]  DIGIT_MAX  = 2'd3;

    typedef logic [VAL_W-1:0] t_digit;
    typedef logic [ROW_DIGITS-1:0][VAL_W-1:0] t_row;

    typedef struct packed {
        logic             found;
        logic             is_two;
        logic [OFF_W-1:0] off;
    } t_scan_res;

endpackage

// ===== rtl/redundant_binary_counter_top.sv =====
// Top level of the redundant binary counter: control sequencer, result buffer
// and configuration register. Depends on rbc_pkg, rbc_row_mem and rbc_row_scan.
//
//   channel   direction  handshake             word
//   input     in         i_start / o_busy      i_bit_position
//   result    out        o_strobe              o_change_count, o_digit_position,
//                                              o_digit_value, o_last_change
//   config    in         i_cfg_we              i_cfg_wdata (digit_count)
//
// An item in range, once accepted, goes through S rows of 16 digits read to find the
// nearest 0 or 2 above the position (1 up to ceil(min(digit_count, MAX_DIGITS)/16)), K
// read-modify-write passes on the digit memory (1 to 4) and R result words (1 to 4). An
// item out of range goes straight to a single result word with a change count of zero.
// After reset a clearing pass writes ceil(MAX_DIGITS/16) rows with o_busy high. Result
// words are shown for one cycle each and are never held.
module redundant_binary_counter_top #(
    parameter int MAX_DIGITS = rbc_pkg::DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [rbc_pkg::POS_IN_W-1:0]  i_bit_position,
    output logic                          o_strobe,
    output logic [rbc_pkg::CHG_W-1:0]     o_change_count,
    output logic [rbc_pkg::POS_IN_W-1:0]  o_digit_position,
    output logic [rbc_pkg::VAL_W-1:0]     o_digit_value,
    output logic                          o_last_change,
    input  logic                          i_cfg_we,
    input  logic [rbc_pkg::DCNT_W-1:0]    i_cfg_wdata
);
    import rbc_pkg::*;

    localparam int ROWS   = (MAX_DIGITS + ROW_DIGITS - 1) / ROW_DIGITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW     = ROW_AW + OFF_W;
    localparam int NW     = PW + 1;
    localparam int CW     = (NW > DCNT_W) ? NW : DCNT_W;

    typedef logic [PW-1:0] t_pos;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_OP_RD,
        ST_OP_WR,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_X,
        OP_INC,
        OP_CLR,
        OP_ONE
    } t_op_kind;

    function automatic t_digit upd_digit(input t_op_kind k, input t_digit d);
        t_digit v;
        v = d;
        unique case (k)
            OP_X:    v = (d == DIGIT_ZERO) ? DIGIT_ONE : d - DIGIT_ONE;
            OP_INC:  v = (d == DIGIT_MAX) ? DIGIT_MAX : d + DIGIT_ONE;
            OP_CLR:  v = DIGIT_ZERO;
            OP_ONE:  v = DIGIT_ONE;
            default: v = d;
        endcase
        return v;
    endfunction

    t_state                r_state;
    logic [DCNT_W-1:0]     r_digit_count;
    logic [ROW_AW-1:0]     r_clr;
    t_pos                  r_x;
    logic [ROW_AW-1:0]     r_row;
    logic                  r_first;
    t_digit                r_dx;
    t_pos                  r_t;
    logic [3:0]            r_opv;
    logic                  r_op2_one;
    logic [1:0]            r_idx;
    logic [POS_IN_W-1:0]   r_bpos [4];
    t_digit                r_bval [4];
    logic [CHG_W-1:0]      r_cnt;
    logic [1:0]            r_eidx;
    logic                  r_strobe;
    logic [CHG_W-1:0]      r_cc;
    logic [POS_IN_W-1:0]   r_dpos;
    t_digit                r_dval;
    logic                  r_last;

    logic [CW-1:0]         dc_ext;
    logic [CW-1:0]         max_ext;
    logic [CW-1:0]         n_used;
    t_pos                  lp;
    t_pos                  x_in;
    logic                  in_range;
    logic                  accept;
    t_row                  rd_data;
    t_row                  wr_data;
    logic                  mem_we;
    logic                  mem_re;
    logic [ROW_AW-1:0]     mem_waddr;
    logic [ROW_AW-1:0]     mem_raddr;
    logic [ROW_DIGITS-1:0] scan_mask;
    t_scan_res             scan_res;
    logic                  scan_done;
    t_pos                  t_found;
    t_digit                dx_now;
    logic                  cx_now;
    logic                  two_now;
    logic                  tnext_now;
    t_pos                  op_pos;
    t_op_kind              op_kind;
    t_digit                old_digit;
    t_digit                new_digit;
    logic                  nxt_ok;
    logic [1:0]            nxt_idx;

    assign dc_ext   = CW'(r_digit_count);
    assign max_ext  = CW'(MAX_DIGITS);
    assign n_used   = (dc_ext < max_ext) ? dc_ext : max_ext;
    assign lp       = PW'(n_used - CW'(1));
    assign x_in     = PW'(i_bit_position);
    assign in_range = CW'(i_bit_position) < n_used;
    assign o_busy   = (r_state != ST_IDLE);
    assign accept   = i_start && !o_busy;

    always_comb begin
        for (int o = 0; o < ROW_DIGITS; o++) begin
            scan_mask[o] = (!r_first || (OFF_W'(o) > r_x[OFF_W-1:0]))
                        && ((r_row != lp[PW-1:OFF_W]) || (OFF_W'(o) <= lp[OFF_W-1:0]));
        end
    end

    rbc_row_scan u_scan (
        .i_row  (rd_data),
        .i_mask (scan_mask),
        .o_res  (scan_res)
    );

    assign scan_done = scan_res.found || (r_row == lp[PW-1:OFF_W]);
    assign t_found   = {r_row, scan_res.off};
    assign dx_now    = r_first ? rd_data[r_x[OFF_W-1:0]] : r_dx;
    assign cx_now    = (dx_now != DIGIT_ZERO) && (r_x != lp);
    assign two_now   = scan_res.found && scan_res.is_two;
    assign tnext_now = (t_found == r_x + PW'(1));

    always_comb begin
        unique case (r_idx)
            2'd0: begin
                op_pos  = r_x;
                op_kind = OP_X;
            end
            2'd1: begin
                op_pos  = r_x + PW'(1);
                op_kind = OP_INC;
            end
            2'd2: begin
                op_pos  = r_t;
                op_kind = r_op2_one ? OP_ONE : OP_CLR;
            end
            default: begin
                op_pos  = r_t + PW'(1);
                op_kind = OP_INC;
            end
        endcase
    end

    assign old_digit = rd_data[op_pos[OFF_W-1:0]];
    assign new_digit = upd_digit(op_kind, old_digit);

    always_comb begin
        wr_data                      = rd_data;
        wr_data[op_pos[OFF_W-1:0]]   = new_digit;
    end

    always_comb begin
        nxt_ok  = 1'b0;
        nxt_idx = 2'd0;
        for (int j = 3; j >= 0; j--) begin
            if (r_opv[j] && (2'(j) > r_idx)) begin
                nxt_ok  = 1'b1;
                nxt_idx = 2'(j);
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = op_pos[PW-1:OFF_W];
        mem_re    = 1'b0;
        mem_raddr = op_pos[PW-1:OFF_W];
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            ST_IDLE: begin
                mem_re    = accept && in_range;
                mem_raddr = x_in[PW-1:OFF_W];
            end
            ST_SCAN: begin
                mem_re    = !scan_done;
                mem_raddr = r_row + ROW_AW'(1);
            end
            ST_OP_RD: begin
                mem_re = 1'b1;
            end
            ST_OP_WR: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    rbc_row_mem #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ((r_state == ST_CLEAR) ? t_row'('0) : wr_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DCNT_RESET;
        end else if (i_cfg_we) begin
            r_digit_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr == ROW_AW'(ROWS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr <= r_clr + ROW_AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_x     <= x_in;
                        r_row   <= x_in[PW-1:OFF_W];
                        r_first <= 1'b1;
                        r_cnt   <= '0;
                        r_eidx  <= '0;
                        r_state <= in_range ? ST_SCAN : ST_EMIT;
                    end
                end
                ST_SCAN: begin
                    r_dx    <= dx_now;
                    r_first <= 1'b0;
                    if (scan_done) begin
                        r_t       <= t_found;
                        r_opv[0]  <= 1'b1;
                        r_opv[1]  <= cx_now && !(two_now && tnext_now);
                        r_opv[2]  <= two_now;
                        r_opv[3]  <= two_now && (t_found != lp);
                        r_op2_one <= cx_now && tnext_now;
                        r_idx     <= 2'd0;
                        r_state   <= ST_OP_RD;
                    end else begin
                        r_row <= r_row + ROW_AW'(1);
                    end
                end
                ST_OP_RD: begin
                    r_state <= ST_OP_WR;
                end
                ST_OP_WR: begin
                    if (new_digit != old_digit) begin
                        r_bpos[r_cnt[1:0]] <= POS_IN_W'(op_pos);
                        r_bval[r_cnt[1:0]] <= new_digit;
                        r_cnt              <= r_cnt + CHG_W'(1);
                    end
                    if (nxt_ok) begin
                        r_idx   <= nxt_idx;
                        r_state <= ST_OP_RD;
                    end else begin
                        r_eidx  <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_cnt == '0) begin
                        r_cc    <= '0;
                        r_dpos  <= '0;
                        r_dval  <= DIGIT_ZERO;
                        r_last  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cc   <= r_cnt;
                        r_dpos <= r_bpos[r_eidx];
                        r_dval <= r_bval[r_eidx];
                        if (CHG_W'(r_eidx) + CHG_W'(1) == r_cnt) begin
                            r_last  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_last <= 1'b0;
                            r_eidx <= r_eidx + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe         = r_strobe;
    assign o_change_count   = r_cc;
    assign o_digit_position = r_dpos;
    assign o_digit_value    = r_dval;
    assign o_last_change    = r_last;

endmodule

// ===== rtl/rbc_row_mem.sv =====
// Digit memory of the redundant binary counter: one row of digits per entry,
// one write port and one registered read port. Depends on rbc_pkg.
module rbc_row_mem #(
    parameter int ROWS   = rbc_pkg::DEF_MAX_DIGITS / rbc_pkg::ROW_DIGITS,
    parameter int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ROW_AW-1:0] i_waddr,
    input  rbc_pkg::t_row     i_wdata,
    input  logic              i_re,
    input  logic [ROW_AW-1:0] i_raddr,
    output rbc_pkg::t_row     o_rdata
);
    import rbc_pkg::*;

    t_row r_mem [ROWS];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rbc_row_scan.sv =====
// Row scan of the redundant binary counter: finds the lowest enabled digit of
// one row that is 0 or 2. Depends on rbc_pkg.
module rbc_row_scan (
    input  rbc_pkg::t_row                     i_row,
    input  logic [rbc_pkg::ROW_DIGITS-1:0]    i_mask,
    output rbc_pkg::t_scan_res                o_res
);
    import rbc_pkg::*;

    logic [ROW_DIGITS-1:0] hit;

    always_comb begin
        for (int o = 0; o < ROW_DIGITS; o++) begin
            hit[o] = i_mask[o] && (i_row[o] == DIGIT_ZERO || i_row[o] == DIGIT_TWO);
        end
    end

    always_comb begin
        o_res = '0;
        for (int o = ROW_DIGITS - 1; o >= 0; o--) begin
            if (hit[o]) begin
                o_res.found  = 1'b1;
                o_res.is_two = (i_row[o] == DIGIT_TWO);
                o_res.off    = OFF_W'(o);
            end
        end
    end

endmodule
